>>> design/hfpp_pkg.sv
// hfpp_pkg: shared constants and types of the Hopf fiber point projector.
// Holds the sine polynomial coefficients, pipeline depths and the sideband struct.
// No dependencies.
package hfpp_pkg;

  localparam int STEP_W     = 7;
  localparam int STEP_N     = 1 << STEP_W;
  localparam int SIN_STAGES = 7;
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEP   = 3;
  localparam int Q_W        = DIV_STAGES * DIV_STEP;
  localparam int NUM_W      = 35;
  localparam int DEN_W      = 19;
  localparam int LANES      = 3;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [30:0] C1    = 31'd1686629713;
  localparam logic [30:0] C3    = 31'd693598668;
  localparam logic [30:0] C5    = 31'd85569306;
  localparam logic [30:0] C7    = 31'd5026995;
  localparam logic [30:0] C9    = 31'd172272;

  localparam logic signed [18:0] UNIT_Q16 = 19'sd65536;
  localparam logic [Q_W-1:0]     POS_LIM  = 24'd8388607;
  localparam logic [Q_W-1:0]     NEG_LIM  = 24'd8388608;

  typedef struct packed {
    logic [19:0]        seg_start;
    logic [19:0]        seg_end;
    logic signed [17:0] w;
    logic [LANES-1:0]   neg;
    logic [LANES-1:0]   mzero;
    logic               pole;
  } side_t;

endpackage

>>> design/hfpp_sine.sv
// hfpp_sine: pipelined Q1.16 sine of a phase, one turn = 2^BITS.
// Quarter-wave fold, degree-9 odd polynomial in Horner form, one product per stage.
// Depends on hfpp_pkg.
module hfpp_sine import hfpp_pkg::*; #(
  parameter int BITS = 17
) (
  input  logic                     clk,
  input  logic [SIN_STAGES-1:0]    en,
  input  logic [BITS-1:0]          phase,
  output logic signed [17:0]       sin_q16
);

  localparam int QB = BITS - 2;

  logic [30:0]        x_r  [SIN_STAGES-1];
  logic [1:0]         q_r  [SIN_STAGES-1];
  logic [30:0]        x2_r [4];
  logic [30:0]        b_r  [4];
  logic signed [17:0] sin_r;

  logic [30:0] f_ext;
  logic [30:0] x_nxt;
  logic [61:0] sq;
  logic [61:0] vp;
  logic [31:0] v;
  logic [30:0] vc;
  logic [16:0] r;

  assign f_ext = 31'(phase[QB-1:0]) << (30 - QB);
  assign x_nxt = phase[QB] ? (ONE30 - f_ext) : f_ext;
  assign sq    = 62'(x_r[0]) * 62'(x_r[0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0] <= x_nxt;
      q_r[0] <= phase[BITS-1:BITS-2];
    end
    for (int i = 1; i < SIN_STAGES - 1; i++) begin
      if (en[i]) begin
        x_r[i] <= x_r[i-1];
        q_r[i] <= q_r[i-1];
      end
    end
    if (en[1]) begin
      x2_r[0] <= 31'(sq >> 30);
    end
    for (int j = 1; j < 4; j++) begin
      if (en[j+1]) begin
        x2_r[j] <= x2_r[j-1];
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_horner
    localparam logic [30:0] CK = (j == 0) ? C7 : (j == 1) ? C5 : (j == 2) ? C3 : C1;
    logic [30:0] bin;
    logic [61:0] t;
    if (j == 0) begin : g_first
      assign bin = C9;
    end else begin : g_next
      assign bin = b_r[j-1];
    end
    assign t = 62'(x2_r[j]) * 62'(bin);
    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        b_r[j] <= CK - 31'(t >> 30);
      end
    end
  end

  // cap at one, round to Q1.16, apply quadrant sign
  assign vp = 62'(x_r[SIN_STAGES-2]) * 62'(b_r[3]);
  assign v  = 32'(vp >> 30);
  assign vc = (v > 32'(ONE30)) ? ONE30 : v[30:0];
  assign r  = 17'((32'(vc) + 32'd8192) >> 14);

  always_ff @(posedge clk) begin
    if (en[SIN_STAGES-1]) begin
      sin_r <= q_r[SIN_STAGES-2][1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    end
  end

  assign sin_q16 = sin_r;

endmodule

>>> design/hfpp_div.sv
// hfpp_div: pipelined restoring divider, three numerators over one shared divisor.
// Gives a 24-bit quotient plus an overflow flag when the quotient does not fit.
// Depends on hfpp_pkg.
module hfpp_div import hfpp_pkg::*; (
  input  logic                   clk,
  input  logic [DIV_STAGES-1:0]  en,
  input  logic [NUM_W-1:0]       num [LANES],
  input  logic [DEN_W-1:0]       den,
  output logic [Q_W-1:0]         quo [LANES],
  output logic [LANES-1:0]       ovf
);

  localparam int WIDE = DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [DIV_STAGES][LANES];
  logic [Q_W-1:0]   q_r   [DIV_STAGES][LANES];
  logic [LANES-1:0] ovf_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int TOP = Q_W - 1 - s * DIV_STEP;
    logic [NUM_W-1:0] rem_in [LANES];
    logic [Q_W-1:0]   q_in   [LANES];
    logic [LANES-1:0] ovf_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] rem_c  [LANES];
    logic [Q_W-1:0]   q_c    [LANES];

    if (s == 0) begin : g_head
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = num[l];
        assign q_in[l]   = '0;
        assign ovf_in[l] = WIDE'(num[l]) >= (WIDE'(den) << Q_W);
      end
      assign den_in = den;
    end else begin : g_body
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign ovf_in = ovf_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      logic [WIDE-1:0] trial;
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        rem_c[l] = rem_in[l];
        q_c[l]   = q_in[l];
        for (int b = 0; b < DIV_STEP; b++) begin
          trial = WIDE'(den_in) << (TOP - b);
          if (WIDE'(rem_c[l]) >= trial) begin
            rem_c[l] = NUM_W'(WIDE'(rem_c[l]) - trial);
            q_c[l]   = q_c[l] | (Q_W'(1) << (TOP - b));
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_c;
        q_r[s]   <= q_c;
        ovf_r[s] <= ovf_in;
        den_r[s] <= den_in;
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];
  assign ovf = ovf_r[DIV_STAGES-1];

endmodule

>>> design/hopf_fiber_point_projector_unit.sv
// Channel | direction | payload
// in_     | input     | base_angle, tilt_angle, step, circle_base
// out_    | output    | proj_x/y/z, fourth_coord, segment_start/end, clipped
//
// Stages: phase setup, 7 sine stages, product, divide setup,
// 8 divider stages (3 quotient bits each) and the output register.
// One item enters every cycle while in_stall is low.
// rst_n is synchronous and clears only the stage valid bits.
// A stall on out_ holds the output; bubbles ahead of it still fill, then in_stall rises.
// Depends on hfpp_pkg, hfpp_sine, hfpp_div.
module hopf_fiber_point_projector_unit import hfpp_pkg::*; #(
  parameter int POINTS     = 128,
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_base_angle,
  input  logic [14:0]         in_tilt_angle,
  input  logic [STEP_W-1:0]   in_step,
  input  logic [19:0]         in_circle_base,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [23:0]  out_proj_x,
  output logic signed [23:0]  out_proj_y,
  output logic signed [23:0]  out_proj_z,
  output logic signed [17:0]  out_fourth_coord,
  output logic [19:0]         out_segment_start,
  output logic [19:0]         out_segment_end,
  output logic                out_clipped
);

  localparam int AB      = ANGLE_BITS;
  localparam int HB      = AB + 1;
  localparam int ST_MUL  = SIN_STAGES + 1;
  localparam int ST_PREP = ST_MUL + 1;
  localparam int ST_DIV  = ST_PREP + 1;
  localparam int ST_OUT  = ST_DIV + DIV_STAGES;
  localparam int NSTG    = ST_OUT + 1;

  // ---------------- flow control ----------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // ---------------- phase setup ----------------
  logic [HB-1:0] xi2_tbl [STEP_N];
  logic [7:0]    nxt_tbl [STEP_N];

  for (genvar i = 0; i < STEP_N; i++) begin : g_tbl
    localparam logic [63:0] XI2 = (64'(2 * i) << AB) / 64'(POINTS);
    localparam logic [63:0] NXT = 64'((i + 1) % POINTS);
    assign xi2_tbl[i] = XI2[HB-1:0];
    assign nxt_tbl[i] = NXT[7:0];
  end

  logic [AB-1:0] p1;
  logic [AB-1:0] pe;

  if (AB >= 16) begin : g_up
    assign p1 = AB'(in_base_angle) << (AB - 16);
    assign pe = AB'(in_tilt_angle) << (AB - 16);
  end else begin : g_dn
    assign p1 = AB'(in_base_angle >> (16 - AB));
    assign pe = AB'(in_tilt_angle >> (16 - AB));
  end

  logic [HB-1:0] hs;
  logic [HB-1:0] hd;
  logic [HB-1:0] hs_r, hsc_r, hd_r, hdc_r;
  logic [AB-1:0] pe_r, pec_r;
  side_t         side_in;

  assign hs = xi2_tbl[in_step] + HB'(p1);
  assign hd = xi2_tbl[in_step] - HB'(p1);

  always_comb begin
    side_in           = '0;
    side_in.seg_start = in_circle_base + 20'(in_step);
    side_in.seg_end   = in_circle_base + 20'(nxt_tbl[in_step]);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      hs_r  <= hs;
      hsc_r <= hs + (HB'(1) << (HB - 2));
      hd_r  <= hd;
      hdc_r <= hd + (HB'(1) << (HB - 2));
      pe_r  <= pe;
      pec_r <= pe + (AB'(1) << (AB - 2));
    end
  end

  // ---------------- sine units ----------------
  logic signed [17:0] cos_hs, sin_hs, cos_hd, sin_hd, cos_e, sin_e;

  hfpp_sine #(.BITS(HB)) u_cos_hs (
    .clk(clk), .en(rdy[SIN_STAGES:1]), .phase(hsc_r), .sin_q16(cos_hs));
  hfpp_sine #(.BITS(HB)) u_sin_hs (
    .clk(clk), .en(rdy[SIN_STAGES:1]), .phase(hs_r), .sin_q16(sin_hs));
  hfpp_sine #(.BITS(HB)) u_cos_hd (
    .clk(clk), .en(rdy[SIN_STAGES:1]), .phase(hdc_r), .sin_q16(cos_hd));
  hfpp_sine #(.BITS(HB)) u_sin_hd (
    .clk(clk), .en(rdy[SIN_STAGES:1]), .phase(hd_r), .sin_q16(sin_hd));
  hfpp_sine #(.BITS(AB)) u_cos_e (
    .clk(clk), .en(rdy[SIN_STAGES:1]), .phase(pec_r), .sin_q16(cos_e));
  hfpp_sine #(.BITS(AB)) u_sin_e (
    .clk(clk), .en(rdy[SIN_STAGES:1]), .phase(pe_r), .sin_q16(sin_e));

  // ---------------- sideband ----------------
  side_t side_r [ST_OUT];
  side_t side_mul;
  side_t side_prep;

  for (genvar i = 0; i < ST_OUT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        if (i == 0) begin
          side_r[i] <= side_in;
        end else if (i == ST_MUL) begin
          side_r[i] <= side_mul;
        end else if (i == ST_PREP) begin
          side_r[i] <= side_prep;
        end else begin
          side_r[i] <= side_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // ---------------- 4D point ----------------
  function automatic logic signed [17:0] mul_q16(input logic signed [17:0] a,
                                                 input logic signed [17:0] b);
    logic signed [35:0] p;
    logic [35:0]        m;
    logic [16:0]        r;
    p = a * b;
    m = p[35] ? 36'(-p) : 36'(p);
    r = 17'((m + 36'd32768) >> 16);
    return p[35] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  logic signed [17:0] crd_r [LANES];

  always_comb begin
    side_mul   = side_r[ST_MUL-1];
    side_mul.w = mul_q16(sin_hd, sin_e);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_MUL]) begin
      crd_r[0] <= mul_q16(cos_hs, cos_e);
      crd_r[1] <= mul_q16(sin_hs, cos_e);
      crd_r[2] <= mul_q16(cos_hd, sin_e);
    end
  end

  // ---------------- divide setup ----------------
  logic signed [18:0] dsum;
  logic [17:0]        dval;
  logic [16:0]        mag [LANES];
  logic [NUM_W-1:0]   num_r [LANES];
  logic [DEN_W-1:0]   den_r;

  assign dsum = UNIT_Q16 - 19'(side_r[ST_MUL].w);
  assign dval = dsum[17:0];

  always_comb begin
    side_prep      = side_r[ST_MUL];
    side_prep.pole = (dval == '0);
    for (int l = 0; l < LANES; l++) begin
      mag[l]             = 17'(crd_r[l][17] ? -crd_r[l] : crd_r[l]);
      side_prep.neg[l]   = crd_r[l][17];
      side_prep.mzero[l] = (mag[l] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PREP]) begin
      for (int l = 0; l < LANES; l++) begin
        num_r[l] <= NUM_W'({mag[l], 17'b0}) + NUM_W'(dval);
      end
      den_r <= {dval, 1'b0};
    end
  end

  // ---------------- divider ----------------
  logic [Q_W-1:0]   quo [LANES];
  logic [LANES-1:0] ovf;

  hfpp_div u_div (
    .clk (clk),
    .en  (rdy[ST_OUT-1:ST_DIV]),
    .num (num_r),
    .den (den_r),
    .quo (quo),
    .ovf (ovf)
  );

  // ---------------- saturate and output ----------------
  side_t           sd;
  logic [Q_W-1:0]  lim  [LANES];
  logic [Q_W-1:0]  qsat [LANES];
  logic [Q_W-1:0]  res  [LANES];
  logic [LANES-1:0] clip;

  assign sd = side_r[ST_OUT-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lim[l] = sd.neg[l] ? NEG_LIM : POS_LIM;
      if (sd.pole) begin
        qsat[l] = sd.mzero[l] ? '0 : lim[l];
        clip[l] = 1'b1;
      end else if (ovf[l] || (quo[l] > lim[l])) begin
        qsat[l] = lim[l];
        clip[l] = 1'b1;
      end else begin
        qsat[l] = quo[l];
        clip[l] = 1'b0;
      end
      res[l] = sd.neg[l] ? -qsat[l] : qsat[l];
    end
  end

  logic signed [23:0] out_px_r, out_py_r, out_pz_r;
  logic signed [17:0] out_w_r;
  logic [19:0]        out_ss_r, out_se_r;
  logic               out_clip_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_px_r   <= $signed(res[0]);
      out_py_r   <= $signed(res[1]);
      out_pz_r   <= $signed(res[2]);
      out_w_r    <= sd.w;
      out_ss_r   <= sd.seg_start;
      out_se_r   <= sd.seg_end;
      out_clip_r <= |clip;
    end
  end

  assign out_valid         = v_r[ST_OUT];
  assign out_proj_x        = out_px_r;
  assign out_proj_y        = out_py_r;
  assign out_proj_z        = out_pz_r;
  assign out_fourth_coord  = out_w_r;
  assign out_segment_start = out_ss_r;
  assign out_segment_end   = out_se_r;
  assign out_clipped       = out_clip_r;

endmodule

>>> design/hfpp_chk.sv
// hfpp_chk: port-level assertions for the Hopf fiber point projector.
// Bound to hopf_fiber_point_projector_unit; sees only its ports.
module hfpp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [15:0]        in_base_angle,
  input logic [14:0]        in_tilt_angle,
  input logic [6:0]         in_step,
  input logic [19:0]        in_circle_base,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] out_proj_x,
  input logic signed [23:0] out_proj_y,
  input logic signed [23:0] out_proj_z,
  input logic signed [17:0] out_fourth_coord,
  input logic [19:0]        out_segment_start,
  input logic [19:0]        out_segment_end,
  input logic               out_clipped
);

  // hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_proj_x) && $stable(out_proj_y)
      && $stable(out_proj_z) && $stable(out_fourth_coord) && $stable(out_clipped)
      && $stable(out_segment_start) && $stable(out_segment_end))
    else $error("stalled item changed");

  // the sender holds a stalled input item
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_base_angle)
      && $stable(in_tilt_angle) && $stable(in_step) && $stable(in_circle_base))
    else $error("stalled input item changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("item present after reset");

  // the pole always clips
  a_pole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fourth_coord == 18'sd65536 |-> out_clipped)
    else $error("pole item not flagged");

  // off the pole, a clipped item has a coordinate at a limit
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped && out_fourth_coord != 18'sd65536 |->
      out_proj_x == 24'sh7FFFFF || out_proj_x == 24'sh800000 ||
      out_proj_y == 24'sh7FFFFF || out_proj_y == 24'sh800000 ||
      out_proj_z == 24'sh7FFFFF || out_proj_z == 24'sh800000)
    else $error("clipped item has no saturated coordinate");

endmodule

bind hopf_fiber_point_projector_unit hfpp_chk u_hfpp_chk (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for hopf_fiber_point_projector_unit.
// Predicts each projected fiber point in a small scoreboard class; depends on the RTL only.
module testbench;

  typedef struct {
    logic signed [23:0] px, py, pz;
    logic signed [17:0] w;
    logic [19:0]        seg_start, seg_end;
    logic               clip;
  } fiber_point_t;

  class fiber_scoreboard;
    fiber_point_t pending[$];
    int errors = 0;

    localparam longint unsigned ONE30 = 64'd1 << 30;
    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598668;
    localparam longint unsigned K5 = 64'd85569306;
    localparam longint unsigned K7 = 64'd5026995;
    localparam longint unsigned K9 = 64'd172272;

    // phase: one turn = 2^bits, result Q1.16
    function automatic int wave_sin(longint unsigned ph, int bits);
      longint unsigned q, f, x, x2, b, v, r;
      int qb;
      qb = bits - 2;
      ph = ph & ((64'd1 << bits) - 1);
      q = (ph >> qb) & 3;
      f = ph & ((64'd1 << qb) - 1);
      x = f << (30 - qb);
      if (q[0]) x = ONE30 - x;
      x2 = (x * x) >> 30;
      b = K7 - ((x2 * K9) >> 30);
      b = K5 - ((x2 * b) >> 30);
      b = K3 - ((x2 * b) >> 30);
      b = K1 - ((x2 * b) >> 30);
      v = (x * b) >> 30;
      if (v > ONE30) v = ONE30;
      r = (v + 8192) >> 14;
      if (r > 65536) r = 65536;
      return q[1] ? -int'(r) : int'(r);
    endfunction

    function automatic int wave_cos(longint unsigned ph, int bits);
      return wave_sin(ph + (64'd1 << (bits - 2)), bits);
    endfunction

    function automatic int fix_mul(int a, int b);
      longint p, m;
      p = longint'(a) * longint'(b);
      m = (p < 0) ? -p : p;
      m = (m + 32768) >>> 16;
      return (p < 0) ? -int'(m) : int'(m);
    endfunction

    function automatic longint stereo_div(int num, int den, ref logic clip);
      longint m, lim, q;
      m = (num < 0) ? -longint'(num) : longint'(num);
      lim = (num < 0) ? 8388608 : 8388607;
      if (den <= 0) begin
        clip = 1;
        if (m == 0) return 0;
        return (num < 0) ? -lim : lim;
      end
      q = ((m << 17) + den) / (2 * longint'(den));
      if (q > lim) begin
        q = lim;
        clip = 1;
      end
      return (num < 0) ? -q : q;
    endfunction

    function void note_input(logic [15:0] base, logic [14:0] tilt, logic [6:0] k,
                             logic [19:0] cbase);
      fiber_point_t e;
      longint unsigned p2, hs, hd;
      int ce, se, x, y, z, w;
      logic clip;
      p2 = ((64'd2 * k) << 16) / 128;
      hs = (p2 + base) & 64'h1FFFF;
      hd = (p2 - base) & 64'h1FFFF;
      ce = wave_cos(tilt, 16);
      se = wave_sin(tilt, 16);
      x = fix_mul(wave_cos(hs, 17), ce);
      y = fix_mul(wave_sin(hs, 17), ce);
      z = fix_mul(wave_cos(hd, 17), se);
      w = fix_mul(wave_sin(hd, 17), se);
      clip = 0;
      e.px = 24'(stereo_div(x, 65536 - w, clip));
      e.py = 24'(stereo_div(y, 65536 - w, clip));
      e.pz = 24'(stereo_div(z, 65536 - w, clip));
      e.w = 18'(w);
      e.seg_start = cbase + k;
      e.seg_end = 20'(cbase + ((k + 1) % 128));
      e.clip = clip;
      pending = {pending, e};
    endfunction

    function void check_result(fiber_point_t a);
      fiber_point_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.px !== e.px) begin
        $error("proj_x expected %0d got %0d", e.px, a.px); errors++;
      end
      if (a.py !== e.py) begin
        $error("proj_y expected %0d got %0d", e.py, a.py); errors++;
      end
      if (a.pz !== e.pz) begin
        $error("proj_z expected %0d got %0d", e.pz, a.pz); errors++;
      end
      if (a.w !== e.w) begin
        $error("fourth_coord expected %0d got %0d", e.w, a.w); errors++;
      end
      if (a.seg_start !== e.seg_start) begin
        $error("segment_start expected %0d got %0d", e.seg_start, a.seg_start); errors++;
      end
      if (a.seg_end !== e.seg_end) begin
        $error("segment_end expected %0d got %0d", e.seg_end, a.seg_end); errors++;
      end
      if (a.clip !== e.clip) begin
        $error("clipped expected %0d got %0d", e.clip, a.clip); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] in_base_angle = 0;
  logic [14:0] in_tilt_angle = 0;
  logic [6:0] in_step = 0;
  logic [19:0] in_circle_base = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [23:0] out_proj_x, out_proj_y, out_proj_z;
  logic signed [17:0] out_fourth_coord;
  logic [19:0] out_segment_start, out_segment_end;
  logic out_clipped;

  fiber_scoreboard sb = new;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_out = 0;
  int quiet_cycles = 0;

  hopf_fiber_point_projector_unit dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      fiber_point_t a;
      if (in_valid && !in_stall)
        sb.note_input(in_base_angle, in_tilt_angle, in_step, in_circle_base);
      if (out_valid && !out_stall) begin
        a.px = out_proj_x; a.py = out_proj_y; a.pz = out_proj_z;
        a.w = out_fourth_coord;
        a.seg_start = out_segment_start; a.seg_end = out_segment_end;
        a.clip = out_clipped;
        sb.check_result(a);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk)
    out_stall <= hold_out || ($urandom_range(99) < stall_pct);

  task automatic send_point(logic [15:0] base, logic [14:0] tilt, logic [6:0] k,
                            logic [19:0] cbase);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_base_angle <= base;
    in_tilt_angle <= tilt;
    in_step <= k;
    in_circle_base <= cbase;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    logic [14:0] tilt;
    repeat (n) begin
      case ($urandom_range(3))
        0: tilt = 15'd16384;
        1: tilt = 15'($urandom_range(16384));
        default: tilt = 15'($urandom);
      endcase
      send_point(16'($urandom), tilt, 7'($urandom), 20'($urandom));
    end
    in_valid <= 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: extremes, wraps, pole and near-pole points
    send_point(16'd0, 15'd0, 7'd0, 20'd0);
    send_point(16'hFFFF, 15'h7FFF, 7'd127, 20'hFFFFF);
    send_point(16'd0, 15'd16384, 7'd32, 20'd5);
    send_point(16'd32768, 15'd16384, 7'd64, 20'hFFFF0);
    send_point(16'd1, 15'd16384, 7'd32, 20'd100);
    send_point(16'hFFFF, 15'd16384, 7'd32, 20'd100);
    send_point(16'd0, 15'd16383, 7'd32, 20'd7);
    send_point(16'd0, 15'd16380, 7'd32, 20'd7);
    send_point(16'd16384, 15'd8192, 7'd0, 20'hFFFFF);
    send_point(16'd49152, 15'd24576, 7'd96, 20'h80000);
    send_point(16'd0, 15'd16384, 7'd96, 20'd0);
    send_point(16'hAAAA, 15'h5555, 7'h55, 20'hAAAAA);
    send_point(16'h5555, 15'h2AAA, 7'h2A, 20'h55555);
    send_point(16'd12345, 15'd1, 7'd1, 20'd127);
    in_valid <= 0;
    // hold the receiver off so the pipeline fills and backs up
    fork
      begin
        hold_out = 1;
        repeat (200) @(negedge clk);
        hold_out = 0;
      end
      send_random(100);
    join
    idle_pct = 51; stall_pct = 0;  send_random(100);
    idle_pct = 0;  stall_pct = 51; send_random(100);
    idle_pct = 33; stall_pct = 33; send_random(100);
    idle_pct = 0;  stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
